// File: design/canonical_huffman_stream_decoder_assert.svh
`ifndef CANONICAL_HUFFMAN_STREAM_DECODER_ASSERT_SVH
`define CANONICAL_HUFFMAN_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, quiet while reset is applied
`define CHSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is applied
`define CHSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/chsd_pkg.sv
package chsd_pkg;

    // packed header layout
    localparam int NUM_LENGTHS  = 15;
    localparam int LEN_BYTES    = 4;
    localparam int HEADER_BYTES = 19;

    // datapath widths
    localparam int CODE_W = 16;
    localparam int RUN_W  = 18;
    localparam int IDX_W  = 9;
    localparam int LI_W   = 4;
    localparam int POS_W  = 5;
    localparam int CLEN_W = 5;

    // defaults and queue depths
    localparam int DEF_MAX_CODE_LEN = 15;
    localparam int DEF_SYMBOL_DEPTH = 256;
    localparam int CMD_DEPTH        = 4;
    localparam int OUT_DEPTH        = 4;

    typedef enum logic [2:0] {
        CMD_START,
        CMD_LEN,
        CMD_COUNT,
        CMD_SYM,
        CMD_BODY
    } cmd_kind_t;

    // one classified item on its way from front to back
    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        data;
        logic [IDX_W-1:0]  idx;
        logic [LI_W-1:0]   li;
    } cmd_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_LEN,
        FR_COUNTS,
        FR_SYMS,
        FR_BODY
    } front_phase_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_DEC,
        BK_STOP
    } back_phase_t;

endpackage

// File: design/chsd_front.sv
module chsd_front #(
    parameter int SYMBOL_DEPTH = chsd_pkg::DEF_SYMBOL_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      in_byte,
    input  logic            start_req,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            q_full,
    output logic            q_push,
    output chsd_pkg::cmd_t  q_cmd
);
    import chsd_pkg::*;

    front_phase_t      phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  room;
    logic [7:0]        eff;
    logic [POS_W-1:0]  li_full;
    logic              accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign room     = IDX_W'(SYMBOL_DEPTH) - total_reg;
    assign eff      = ({1'b0, in_byte} < room) ? in_byte : room[7:0];
    assign li_full  = pos_reg - POS_W'(LEN_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= FR_IDLE;
            pos_reg   <= '0;
            total_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            fill_reg  <= fill_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        fill_next  = fill_reg;
        q_push     = 1'b0;
        q_cmd.kind = CMD_BODY;
        q_cmd.data = in_byte;
        q_cmd.idx  = fill_reg;
        q_cmd.li   = li_full[LI_W-1:0];
        if (accept)
        begin
            if (start_req)
            begin
                // a start drops whatever was going on
                q_push     = 1'b1;
                q_cmd.kind = CMD_START;
                phase_next = FR_LEN;
                pos_next   = POS_W'(1);
                total_next = '0;
                fill_next  = '0;
            end
            else
            begin
                unique case (phase_reg)
                    FR_IDLE:
                    begin
                        // stray bytes before any start are dropped
                    end
                    FR_LEN:
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_LEN;
                        pos_next   = pos_reg + POS_W'(1);
                        if (pos_reg == POS_W'(LEN_BYTES - 1))
                        begin
                            phase_next = FR_COUNTS;
                        end
                    end
                    FR_COUNTS:
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_COUNT;
                        q_cmd.data = eff;
                        q_cmd.idx  = total_reg;
                        total_next = total_reg + IDX_W'(eff);
                        pos_next   = pos_reg + POS_W'(1);
                        if (pos_reg == POS_W'(HEADER_BYTES - 1))
                        begin
                            fill_next  = '0;
                            phase_next = (total_next != '0) ? FR_SYMS : FR_BODY;
                        end
                    end
                    FR_SYMS:
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_SYM;
                        fill_next  = fill_reg + IDX_W'(1);
                        if (fill_next >= total_reg)
                        begin
                            phase_next = FR_BODY;
                        end
                    end
                    FR_BODY:
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_BODY;
                    end
                    default:
                    begin
                        phase_next = FR_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// File: design/chsd_cmd_fifo.sv
module chsd_cmd_fifo #(
    parameter int DEPTH = chsd_pkg::CMD_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  chsd_pkg::cmd_t  din,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output chsd_pkg::cmd_t  head
);
    import chsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= din;
        end
    end

endmodule

// File: design/chsd_back.sv
module chsd_back #(
    parameter int MAX_CODE_LEN = chsd_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_DEPTH = chsd_pkg::DEF_SYMBOL_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  chsd_pkg::cmd_t  q_head,
    output logic            q_pop,
    output logic [7:0]      symbol,
    output logic            last,
    output logic            out_valid,
    input  logic            out_stall
);
    import chsd_pkg::*;

    localparam int ADDR_W = (SYMBOL_DEPTH > 1) ? $clog2(SYMBOL_DEPTH) : 1;
    localparam int OPTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    // table, written while the header streams through
    logic [7:0]         cnt_reg   [NUM_LENGTHS];
    logic [CODE_W-1:0]  fcode_reg [NUM_LENGTHS];
    logic [IDX_W-1:0]   fidx_reg  [NUM_LENGTHS];
    logic [7:0]         sym_mem   [SYMBOL_DEPTH];
    logic [7:0]         sym_q_reg;

    back_phase_t        phase_reg, phase_next;
    logic [31:0]        ml_reg, ml_next;
    logic [31:0]        dc_reg, dc_next;
    logic [CODE_W-1:0]  acc_reg, acc_next;
    logic [CLEN_W-1:0]  clen_reg, clen_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [7:0]         shift_reg, shift_next;
    logic [2:0]         bit_reg, bit_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_last_reg, rd_last_next;

    // result buffer
    logic [7:0]         osym_reg  [OUT_DEPTH];
    logic               olast_reg [OUT_DEPTH];
    logic [OPTR_W-1:0]  owr_reg, ord_reg;
    logic [OCNT_W-1:0]  ocnt_reg;
    logic               opush, opop;

    // one bit of code matching
    logic               bit_in;
    logic [CODE_W-1:0]  acc_new;
    logic [CLEN_W-1:0]  clen_new;
    logic [CLEN_W-1:0]  lut_raw;
    logic [LI_W-1:0]    lut;
    logic               lut_ok;
    logic [CODE_W-1:0]  fc;
    logic [CODE_W-1:0]  off;
    logic               in_range;
    logic [IDX_W:0]     idx_sum;
    logic               hit;
    logic [31:0]        dc_inc;
    logic               is_last;
    logic               stop_now;
    logic               room_ok;
    logic               step;
    logic               finishing;
    logic               rd_en;
    logic [RUN_W-1:0]   run_sum;
    logic               tbl_we;
    logic               mem_we;

    assign bit_in   = shift_reg[7];
    assign acc_new  = {acc_reg[CODE_W-2:0], bit_in};
    assign clen_new = clen_reg + CLEN_W'(1);
    assign lut_ok   = (clen_new <= CLEN_W'(NUM_LENGTHS));
    assign lut_raw  = clen_new - CLEN_W'(1);
    assign lut      = lut_ok ? lut_raw[LI_W-1:0] : '0;
    assign fc       = fcode_reg[lut];
    assign off      = acc_new - fc;
    assign in_range = (acc_new >= fc) && (off < {8'b0, cnt_reg[lut]});
    assign idx_sum  = {1'b0, fidx_reg[lut]} + {2'b0, off[7:0]};
    assign hit      = lut_ok && in_range && (idx_sum < (IDX_W + 1)'(SYMBOL_DEPTH));
    assign dc_inc   = (dc_reg == '1) ? dc_reg : dc_reg + 32'd1;
    assign is_last  = (dc_inc >= ml_reg);
    assign stop_now = hit ? is_last : (clen_new >= CLEN_W'(MAX_CODE_LEN));

    // keep a slot free for the read that is in flight
    assign room_ok   = (ocnt_reg + OCNT_W'(rd_pend_reg)) < OCNT_W'(OUT_DEPTH);
    assign step      = (phase_reg == BK_DEC) && room_ok;
    assign finishing = step && (bit_reg == 3'd7) && !stop_now;

    assign q_pop = q_valid && ((phase_reg != BK_DEC)
                            || (finishing && (q_head.kind == CMD_BODY)));

    assign run_sum = run_reg + RUN_W'(q_head.data);
    assign tbl_we  = q_pop && (q_head.kind == CMD_COUNT);
    assign mem_we  = q_pop && (q_head.kind == CMD_SYM);

    always_comb
    begin
        phase_next   = phase_reg;
        ml_next      = ml_reg;
        dc_next      = dc_reg;
        acc_next     = acc_reg;
        clen_next    = clen_reg;
        run_next     = run_reg;
        shift_next   = shift_reg;
        bit_next     = bit_reg;
        rd_pend_next = 1'b0;
        rd_last_next = rd_last_reg;
        rd_en        = 1'b0;
        if (step)
        begin
            shift_next = {shift_reg[6:0], 1'b0};
            bit_next   = bit_reg + 3'd1;
            if (hit)
            begin
                acc_next     = '0;
                clen_next    = '0;
                dc_next      = dc_inc;
                rd_en        = 1'b1;
                rd_pend_next = 1'b1;
                rd_last_next = is_last;
            end
            else
            begin
                acc_next  = acc_new;
                clen_next = clen_new;
            end
            if (stop_now)
            begin
                phase_next = BK_STOP;
            end
            else if (bit_reg == 3'd7)
            begin
                phase_next = BK_RUN;
            end
        end
        if (q_pop)
        begin
            unique case (q_head.kind)
                CMD_START:
                begin
                    ml_next    = {24'b0, q_head.data};
                    dc_next    = '0;
                    acc_next   = '0;
                    clen_next  = '0;
                    run_next   = '0;
                    phase_next = BK_RUN;
                end
                CMD_LEN:
                begin
                    ml_next = {ml_reg[23:0], q_head.data};
                end
                CMD_COUNT:
                begin
                    run_next = {run_sum[RUN_W-2:0], 1'b0};
                end
                CMD_SYM:
                begin
                end
                CMD_BODY:
                begin
                    if (phase_reg != BK_STOP)
                    begin
                        shift_next = q_head.data;
                        bit_next   = '0;
                        phase_next = BK_DEC;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= BK_RUN;
            ml_reg      <= '0;
            dc_reg      <= '0;
            acc_reg     <= '0;
            clen_reg    <= '0;
            run_reg     <= '0;
            shift_reg   <= '0;
            bit_reg     <= '0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            ml_reg      <= ml_next;
            dc_reg      <= dc_next;
            acc_reg     <= acc_next;
            clen_reg    <= clen_next;
            run_reg     <= run_next;
            shift_reg   <= shift_next;
            bit_reg     <= bit_next;
            rd_pend_reg <= rd_pend_next;
            rd_last_reg <= rd_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            cnt_reg[q_head.li]   <= q_head.data;
            fidx_reg[q_head.li]  <= q_head.idx;
            fcode_reg[q_head.li] <= run_reg[CODE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sym_mem[q_head.idx[ADDR_W-1:0]] <= q_head.data;
        end
        if (rd_en)
        begin
            sym_q_reg <= sym_mem[idx_sum[ADDR_W-1:0]];
        end
    end

    assign opush     = rd_pend_reg;
    assign out_valid = (ocnt_reg != '0);
    assign opop      = out_valid && !out_stall;
    assign symbol    = osym_reg[ord_reg];
    assign last      = olast_reg[ord_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            if (opush)
            begin
                owr_reg <= owr_reg + OPTR_W'(1);
            end
            if (opop)
            begin
                ord_reg <= ord_reg + OPTR_W'(1);
            end
            if (opush && !opop)
            begin
                ocnt_reg <= ocnt_reg + OCNT_W'(1);
            end
            else if (opop && !opush)
            begin
                ocnt_reg <= ocnt_reg - OCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (opush)
        begin
            osym_reg[owr_reg]  <= sym_q_reg;
            olast_reg[owr_reg] <= rd_last_reg;
        end
    end

endmodule

// File: design/canonical_huffman_stream_decoder.sv
// path: body byte into a shift register, symbol read register, then result buffer
// throughput: one header byte per cycle unless the queue is full, one body bit
// per cycle given output room, set by the bit-serial match loop in the back end
// reset: asynchronous, active low; both queues empty, waiting for a start item
// code tables and symbol memory are not cleared, every entry read is written first
module canonical_huffman_stream_decoder #(
    parameter int MAX_CODE_LEN = chsd_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_DEPTH = chsd_pkg::DEF_SYMBOL_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_byte,
    input  logic        start_req,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [7:0]  symbol,
    output logic        last,
    output logic        out_valid,
    input  logic        out_stall
);
    import chsd_pkg::*;

    // front end: tracks the header layout and tags each item
    //   start, length byte, code count (clamped), symbol byte or body byte
    // the tag travels with the byte through a short command queue, so the
    // back end never sees a table write while an older body byte is still
    // being decoded, and a restart simply queues behind the old message

    logic  q_push;
    cmd_t  q_cmd;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    cmd_t  q_head;

    chsd_front #(
        .SYMBOL_DEPTH (SYMBOL_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .start_req (start_req),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // command queue: lets the input keep flowing while the back end works
    // through a body byte bit by bit
    chsd_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .head  (q_head)
    );

    // back end: builds first code and first index per length as counts
    // arrive, stores symbols, then matches body bits msb first one per cycle
    // while output room remains; a hit reads the symbol memory and the registered
    // data lands in a small result buffer, which decouples out_stall from the loop
    chsd_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_DEPTH (SYMBOL_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .symbol    (symbol),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

// File: design/chsd_checker.sv
`include "canonical_huffman_stream_decoder_assert.svh"

module chsd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start_req,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  symbol,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_stall
);

    logic started_reg;

    // set once any start item has gone in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
        end
        else if (in_valid && !in_stall && start_req)
        begin
            started_reg <= 1'b1;
        end
    end

    `CHSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(symbol) && $stable(last), "stalled result changed")
    `CHSD_ASSERT_SAME(a_out_after_start, out_valid, $past(started_reg, 2), "result before any start")
    `CHSD_ASSERT_SAME(a_stall_rise, $rose(in_stall), $past(in_valid && !in_stall), "queue filled without an item")

endmodule

bind canonical_huffman_stream_decoder chsd_checker u_chsd_checker (.*);

// File: bench/canonical_huffman_stream_decoder_test.sv
module canonical_huffman_stream_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import chsd_pkg::*;

    // decoder built with its default sizes
    localparam int MAX_CODE_LEN = DEF_MAX_CODE_LEN;
    localparam int SYMBOL_DEPTH = DEF_SYMBOL_DEPTH;

    // run control
    localparam int CLK_HALF     = 10;
    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_OFF     = 300;   // long receiver freeze for the back-pressure test
    localparam int DRAIN_CYCLES = 40;    // a few body bytes' worth after the last symbol
    localparam int STALL_LIMIT  = 3000;  // cycles with no item moving on either side

    // where the decoder stands within a message, as the predictor tracks it
    typedef enum int {
        MP_IDLE,
        MP_LEN,
        MP_COUNTS,
        MP_SYMS,
        MP_BODY,
        MP_STOP
    } msg_phase_t;

    // one decoded symbol as it should leave the block
    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } decoded_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       start_req = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] symbol;
    logic       last;
    logic       out_valid;
    logic       out_stall = 1'b0;

    // symbols still owed by the decoder, oldest first
    decoded_t expected_symbols[$];

    // predictor state, mirrors the decoder's own registers and tables
    msg_phase_t  dec_phase;
    int          hdr_pos;
    logic [31:0] declared_len;
    int          len_count [NUM_LENGTHS];
    logic [15:0] first_cd  [NUM_LENGTHS];
    int          first_idx [NUM_LENGTHS];
    logic [7:0]  sym_mem   [SYMBOL_DEPTH];
    int          sym_total;
    int          sym_fill;
    logic [15:0] acc;
    int          acc_len;
    logic [31:0] decoded_so_far;

    // bookkeeping
    int error_count       = 0;
    int symbols_checked   = 0;
    int taken_items       = 0;
    int messages_opened   = 0;
    int send_quiet_left   = 0;
    int take_quiet_left   = 0;
    int hold_off_cycles   = 0;

    canonical_huffman_stream_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .start_req (start_req),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .symbol    (symbol),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    // 20 ns clock
    initial
    begin
        forever
        begin
            #(CLK_HALF) clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // walks one accepted item through the message; queues any symbols it
    // decodes and tells whether the decoder made any use of the item
    function automatic bit decode_byte(input logic [7:0] b, input logic opens);
        decoded_t    res;
        logic [17:0] run;
        logic [15:0] offs;
        int          room;
        int          eff;
        int          li;
        int          idx;
        int          i;
        int          k;
        bit          hit;
        bit          used;

        used = opens || (dec_phase != MP_IDLE && dec_phase != MP_STOP);

        // a start drops whatever was going on, even mid body
        if (opens)
        begin
            declared_len   = {24'd0, b};
            hdr_pos        = 1;
            dec_phase      = MP_LEN;
            sym_total      = 0;
            sym_fill       = 0;
            acc            = '0;
            acc_len        = 0;
            decoded_so_far = '0;
            return used;
        end

        case (dec_phase)
            MP_LEN:
            begin
                // big-endian symbol count
                declared_len = {declared_len[23:0], b};
                hdr_pos++;
                if (hdr_pos >= LEN_BYTES)
                    dec_phase = MP_COUNTS;
            end
            MP_COUNTS:
            begin
                // clamp so the running total never passes the store depth
                li   = hdr_pos - LEN_BYTES;
                room = SYMBOL_DEPTH - sym_total;
                eff  = (int'(b) < room) ? int'(b) : room;
                len_count[li] = eff;
                first_idx[li] = sym_total;
                sym_total    += eff;
                hdr_pos++;
                if (hdr_pos >= HEADER_BYTES)
                begin
                    // canonical first codes, running code kept to 18 bits
                    run = '0;
                    for (i = 0; i < NUM_LENGTHS; i++)
                    begin
                        first_cd[i] = run[15:0];
                        run = (run + len_count[i]) << 1;
                    end
                    sym_fill  = 0;
                    dec_phase = (sym_total != 0) ? MP_SYMS : MP_BODY;
                end
            end
            MP_SYMS:
            begin
                if (sym_fill < SYMBOL_DEPTH)
                    sym_mem[sym_fill] = b;
                sym_fill++;
                if (sym_fill >= sym_total)
                    dec_phase = MP_BODY;
            end
            MP_BODY:
            begin
                // msb first, one match attempt per bit
                for (k = 7; k >= 0 && dec_phase == MP_BODY; k--)
                begin
                    hit = 1'b0;
                    acc = {acc[14:0], b[k]};
                    acc_len++;
                    if (acc_len <= NUM_LENGTHS)
                    begin
                        li   = acc_len - 1;
                        offs = acc - first_cd[li];
                        if (acc >= first_cd[li] && int'(offs) < len_count[li])
                        begin
                            idx = first_idx[li] + int'(offs);
                            if (idx < SYMBOL_DEPTH)
                            begin
                                hit = 1'b1;
                                if (decoded_so_far != '1)
                                    decoded_so_far++;
                                res.value   = sym_mem[idx];
                                res.is_last = (decoded_so_far >= declared_len);
                                expected_symbols = {expected_symbols, res};
                                if (res.is_last)
                                    dec_phase = MP_STOP;
                                acc     = '0;
                                acc_len = 0;
                            end
                        end
                    end
                    // nothing matched within the longest code length
                    if (!hit && acc_len >= MAX_CODE_LEN)
                        dec_phase = MP_STOP;
                end
            end
            default:
            begin
            end
        endcase
        return used;
    endfunction

    // ------------------------------------------------------------------
    // handshake helpers
    // ------------------------------------------------------------------

    // idle cycles before the next item, with occasional runs of back-to-back items
    function automatic int draw_gap(ref int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            quiet_left = $urandom_range(8, 40);
        return $urandom_range(0, 14);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $realtime, what);
        error_count++;
    endtask

    // offers one item and holds it until the decoder takes it
    task automatic send_byte(input logic [7:0] value, input logic opens);
        int gap;
        gap = draw_gap(send_quiet_left);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= value;
        start_req <= opens;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (decode_byte(value, opens))
            taken_items++;
        if (opens)
            messages_opened++;
    endtask

    task automatic check_result(input logic [7:0] got_sym, input logic got_last);
        decoded_t want;
        if (expected_symbols.size() == 0)
        begin
            report_mismatch($sformatf("symbol %02h last %b with none outstanding",
                                      got_sym, got_last));
            return;
        end
        want = expected_symbols.pop_front();
        if (got_sym !== want.value)
            report_mismatch($sformatf("symbol %02h, wanted %02h", got_sym, want.value));
        if (got_last !== want.is_last)
            report_mismatch($sformatf("last %b on symbol %02h, wanted %b",
                                      got_last, want.value, want.is_last));
        symbols_checked++;
    endtask

    // result side: checks every taken symbol and draws its own stalls;
    // a pending hold-off freezes it completely
    initial
    begin : result_side
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                check_result(symbol, last);
                hold = draw_gap(take_quiet_left);
            end
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_off_cycles--;
            end
            else if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog on traffic: fails the run if nothing moves for too long
    initial
    begin : traffic_watch
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("timeout: nothing moved for %0d cycles, %0d symbols outstanding",
                         quiet, expected_symbols.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    // code-length counts that respect the code space, mostly short codes
    function automatic void pick_code_lengths(output int counts[NUM_LENGTHS]);
        int cap;
        int deepest;
        int lim;
        int i;
        deepest = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
        cap = 2;
        for (i = 0; i < NUM_LENGTHS; i++)
        begin
            if (i >= deepest)
                counts[i] = 0;
            else if (i == deepest - 1)
                counts[i] = (cap <= 12) ? cap : $urandom_range(1, 12);
            else
            begin
                lim = (cap - 1 < 3) ? cap - 1 : 3;
                counts[i] = $urandom_range(0, lim);
            end
            cap = (cap - counts[i]) * 2;
        end
    endfunction

    // declared length: mostly exact, sometimes short, zero or unreachable
    function automatic logic [31:0] pick_length(input int n_codes);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return n_codes - $urandom_range(0, n_codes);
            4:       return n_codes + $urandom_range(1, 3);
            default: return n_codes;
        endcase
    endfunction

    // header, random symbol bytes, then a body that encodes n_codes random
    // symbols of the table, padded with random bits, then extra trailing bytes
    task automatic send_message(input int counts[NUM_LENGTHS], input logic [31:0] msg_len,
                                input int n_codes, input int extra_bytes);
        int          eff[NUM_LENGTHS];
        logic [15:0] code_val[$];
        int          code_bits[$];
        bit          stream_bits[$];
        int          total;
        int          room;
        int          code;
        int          pick;
        int          i;
        int          j;
        logic [7:0]  b;

        total = 0;
        for (i = 0; i < NUM_LENGTHS; i++)
        begin
            room   = SYMBOL_DEPTH - total;
            eff[i] = (counts[i] < room) ? counts[i] : room;
            total += eff[i];
        end

        send_byte(msg_len[31:24], 1'b1);
        send_byte(msg_len[23:16], 1'b0);
        send_byte(msg_len[15:8], 1'b0);
        send_byte(msg_len[7:0], 1'b0);
        for (i = 0; i < NUM_LENGTHS; i++)
            send_byte(counts[i][7:0], 1'b0);
        for (i = 0; i < total; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);

        // canonical code list for the encoder side
        code = 0;
        for (i = 0; i < NUM_LENGTHS; i++)
        begin
            for (j = 0; j < eff[i]; j++)
            begin
                code_val  = {code_val, 16'(code + j)};
                code_bits = {code_bits, i + 1};
            end
            code = ((code + eff[i]) << 1) & 'h3FFFF;
        end

        for (i = 0; i < n_codes; i++)
        begin
            if (code_val.size() == 0)
            begin
                for (j = 0; j < 8; j++)
                    stream_bits = {stream_bits, 1'($urandom_range(0, 1))};
            end
            else
            begin
                pick = $urandom_range(0, code_val.size() - 1);
                for (j = code_bits[pick] - 1; j >= 0; j--)
                    stream_bits = {stream_bits, code_val[pick][j]};
            end
        end

        while (stream_bits.size() > 0)
        begin
            for (j = 7; j >= 0; j--)
                b[j] = (stream_bits.size() > 0) ? stream_bits.pop_front()
                                                : 1'($urandom_range(0, 1));
            send_byte(b, 1'b0);
        end
        for (i = 0; i < extra_bytes; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // bytes before any start are dropped
    task automatic test_idle_bytes();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // a start in the middle of the length field abandons that message
    task automatic test_restart();
        send_byte(8'hA5, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // declared length of zero still lets the first symbol out, flagged last
    task automatic test_zero_length();
        int counts[NUM_LENGTHS];
        counts    = '{default: 0};
        counts[0] = 2;
        send_message(counts, 32'd0, 3, 1);
    endtask

    // empty table: body goes straight after the counts and stops after 15 bits
    task automatic test_no_symbols();
        int counts[NUM_LENGTHS];
        counts = '{default: 0};
        send_message(counts, 32'd5, 0, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // only code "0" exists, so a run of ones never matches
    task automatic test_bad_code();
        int counts[NUM_LENGTHS];
        counts    = '{default: 0};
        counts[0] = 1;
        send_message(counts, 32'd100, 0, 0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // one code of each length down to the longest, two at 15 bits
    task automatic test_long_codes();
        int counts[NUM_LENGTHS];
        counts     = '{default: 1};
        counts[14] = 2;
        send_message(counts, 32'd6, 6, 0);
    endtask

    // counts summing past the store depth get clamped, later lengths get none
    task automatic test_count_overflow();
        int counts[NUM_LENGTHS];
        counts    = '{default: 0};
        counts[7] = 200;
        counts[8] = 100;
        counts[9] = 9;
        send_message(counts, 32'd16, 16, 0);
    endtask

    // one-bit codes give eight symbols per byte; the receiver freezes while
    // the sender keeps going, so the decoder backs up onto its input
    task automatic test_backpressure();
        int counts[NUM_LENGTHS];
        counts    = '{default: 0};
        counts[0] = 2;
        send_message(counts, 32'hFFFF_FFFF, 0, 0);
        hold_off_cycles = HOLD_OFF;
        send_message(counts, 32'hFFFF_FFFF, 256, 0);
    endtask

    // mostly well-formed messages with random tables and bodies, plus noise,
    // truncated headers and tables that oversubscribe the code space
    task automatic test_random_messages();
        int          counts[NUM_LENGTHS];
        int          goal;
        int          n_codes;
        int          i;
        logic [31:0] msg_len;
        goal = taken_items + RANDOM_ITEMS;
        while (taken_items < goal)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    // stray bytes, now and then a start among them
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
                8:
                begin
                    // header cut short by the next message
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    repeat ($urandom_range(0, 20))
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                9:
                begin
                    // random small counts, often oversubscribed
                    for (i = 0; i < NUM_LENGTHS; i++)
                        counts[i] = $urandom_range(0, 2);
                    n_codes = $urandom_range(1, 12);
                    msg_len = pick_length(n_codes);
                    send_message(counts, msg_len, n_codes, $urandom_range(0, 2));
                end
                default:
                begin
                    pick_code_lengths(counts);
                    n_codes = $urandom_range(1, 24);
                    msg_len = pick_length(n_codes);
                    send_message(counts, msg_len, n_codes, $urandom_range(0, 2));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        dec_phase      = MP_IDLE;
        hdr_pos        = 0;
        declared_len   = '0;
        sym_total      = 0;
        sym_fill       = 0;
        acc            = '0;
        acc_len        = 0;
        decoded_so_far = '0;
        sym_mem        = '{default: 8'h00};

        // reset held low at first, then released at a clock edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_bytes();
        test_restart();
        test_zero_length();
        test_no_symbols();
        test_bad_code();
        test_long_codes();
        test_count_overflow();
        test_backpressure();
        test_random_messages();
        in_valid <= 1'b0;

        // let every owed symbol arrive, then watch a little longer for strays
        while (expected_symbols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d messages, %0d bytes used by the decoder",
                 messages_opened, taken_items);
        $display("checked %0d decoded symbols, %0d mismatches", symbols_checked, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
